>>> src/pfrgb_pkg.sv
// shared types and constants for the pixel format to rgb byte converter
package pfrgb_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 14;
  localparam int unsigned WidthW   = 14;
  localparam int unsigned ColW     = 13;
  localparam int unsigned MaxWidth = 8192;

  // source pixel formats
  typedef enum logic [2:0] {
    FmtRgba       = 3'd0,
    FmtBgr        = 3'd1,
    FmtBgra       = 3'd2,
    FmtFloatDepth = 3'd3,
    FmtDepth24    = 3'd4,
    FmtDepth16    = 3'd5
  } fmt_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegSourceFormat = 8'd0,
    RegRgbOrder     = 8'd1,
    RegAlphaOut     = 8'd2,
    RegRowWidth     = 8'd3
  } reg_idx_e;

  // decoded color channels of one pixel
  typedef struct packed {
    logic [ByteW-1:0] r;
    logic [ByteW-1:0] g;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] a;
  } color_t;

endpackage

>>> src/pfrgb_convert.sv
// decodes one source pixel word into r, g, b and alpha channel bytes
module pfrgb_convert (
  input  logic [pfrgb_pkg::WordW-1:0] pixel_word_i,
  input  pfrgb_pkg::fmt_e             fmt_i,
  output pfrgb_pkg::color_t           color_o
);
  import pfrgb_pkg::*;

  logic [7:0]  b0, b1, b2, b3;

  // 24-bit unorm depth: floor(v * 255 / (2^24 - 1))
  logic [23:0] v24;
  logic [31:0] x24;
  logic [24:0] r24;
  logic [7:0]  d24;

  // 16-bit unorm depth: floor(v * 255 / (2^16 - 1))
  logic [15:0] v16;
  logic [23:0] x16;
  logic [16:0] r16;
  logic [7:0]  d16;

  // float depth: floor(f * 255), saturated
  logic        f_sign;
  logic [7:0]  f_expo;
  logic [22:0] f_mant;
  logic [23:0] f_m;
  logic [31:0] f_p;
  logic [7:0]  f_sh_full;
  logic [2:0]  f_sh;
  logic [31:0] f_shifted;
  logic [7:0]  dflt;

  assign {b3, b2, b1, b0} = pixel_word_i;

  // x = q0 * 2^24 + lo = q0 * (2^24 - 1) + q0 + lo, one correction step
  assign v24 = pixel_word_i[23:0];
  assign x24 = {v24, 8'h00} - {8'h00, v24};
  assign r24 = {1'b0, x24[23:0]} + {17'd0, x24[31:24]};
  assign d24 = x24[31:24] + {7'd0, (r24 >= 25'h0FF_FFFF)};

  assign v16 = pixel_word_i[15:0];
  assign x16 = {v16, 8'h00} - {8'h00, v16};
  assign r16 = {1'b0, x16[15:0]} + {9'd0, x16[23:16]};
  assign d16 = x16[23:16] + {7'd0, (r16 >= 17'h0FFFF)};

  assign f_sign    = pixel_word_i[31];
  assign f_expo    = pixel_word_i[30:23];
  assign f_mant    = pixel_word_i[22:0];
  assign f_m       = {1'b1, f_mant};
  assign f_p       = {f_m, 8'h00} - {8'h00, f_m};
  assign f_sh_full = 8'd126 - f_expo;
  assign f_sh      = f_sh_full[2:0];
  assign f_shifted = f_p >> (5'd24 + {2'b00, f_sh});

  // only exponents 119..126 leave a nonzero floor below 255
  always_comb begin
    if (f_sign) begin
      dflt = 8'h00;
    end else if (f_expo == 8'hFF) begin
      dflt = (f_mant != 23'd0) ? 8'h00 : 8'hFF;
    end else if (f_expo >= 8'd127) begin
      dflt = 8'hFF;
    end else if (f_expo < 8'd119) begin
      dflt = 8'h00;
    end else begin
      dflt = f_shifted[7:0];
    end
  end

  always_comb begin
    color_o = '{r: 8'h00, g: 8'h00, b: 8'h00, a: 8'hFF};
    case (fmt_i)
      FmtRgba: begin
        color_o = '{r: b0, g: b1, b: b2, a: b3};
      end
      FmtBgr: begin
        color_o = '{r: b2, g: b1, b: b0, a: 8'hFF};
      end
      FmtBgra: begin
        color_o = '{r: b2, g: b1, b: b0, a: b3};
      end
      FmtFloatDepth: begin
        color_o = '{r: dflt, g: dflt, b: dflt, a: 8'hFF};
      end
      FmtDepth24: begin
        color_o = '{r: d24, g: d24, b: d24, a: 8'hFF};
      end
      FmtDepth16: begin
        color_o = '{r: d16, g: d16, b: d16, a: 8'hFF};
      end
      default: begin
        color_o = '{r: 8'h00, g: 8'h00, b: 8'h00, a: 8'hFF};
      end
    endcase
  end

endmodule

>>> src/pixel_format_to_rgb_bytes.sv
// top level: pixel word in, converted image bytes out, one byte per transfer
//
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------------------------
//   cfg     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//   in      | in_valid_i / in_ready_o    | pixel_word_i
//   out     | out_valid_o / out_ready_i  | out_byte_o, is_padding_o, last_of_pixel_o
//
// a pixel waits in the input register, then its 3 to 6 bytes
// (color, optional alpha, row-end padding) leave the byte buffer one per cycle while out_ready_i is high
// the input register takes the next pixel while the buffer still drains
// reset restores the register defaults and returns to column 0; no clearing pass
// a stall on the output holds the buffer, then fills the input register
module pixel_format_to_rgb_bytes (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pfrgb_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [pfrgb_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [pfrgb_pkg::WordW-1:0]        pixel_word_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [pfrgb_pkg::ByteW-1:0]        out_byte_o,
  output logic                               is_padding_o,
  output logic                               last_of_pixel_o
);
  import pfrgb_pkg::*;

  // configuration registers
  fmt_e              fmt_q;
  logic              rgb_order_q;
  logic              alpha_out_q;
  logic [WidthW-1:0] row_width_q;

  // input register
  logic              s1_valid_q, s1_valid_d;
  logic [WordW-1:0]  s1_word_q;

  // row position
  logic [ColW-1:0]   col_q, col_d;

  // byte buffer and serializer
  logic              buf_valid_q, buf_valid_d;
  logic [ByteW-1:0]  bytes_q [4];
  logic [2:0]        n_data_q;
  logic [1:0]        n_pad_q;
  logic [2:0]        idx_q, idx_d;

  logic              in_fire, out_fire, buf_done, s1_move, out_last, is_data;
  logic [2:0]        n_total;
  color_t            color;
  logic [WidthW-1:0] eff_width;
  logic              row_end;
  logic [1:0]        pad_n;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= FmtBgra;
      rgb_order_q <= 1'b0;
      alpha_out_q <= 1'b1;
      row_width_q <= WidthW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegSourceFormat: fmt_q       <= fmt_e'(cfg_data_i[2:0]);
        RegRgbOrder:     rgb_order_q <= cfg_data_i[0];
        RegAlphaOut:     alpha_out_q <= cfg_data_i[0];
        RegRowWidth:     row_width_q <= cfg_data_i[WidthW-1:0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  pfrgb_convert u_convert (
    .pixel_word_i (s1_word_q),
    .fmt_i        (fmt_q),
    .color_o      (color)
  );

  // zero width reads as one, anything past the limit as the limit
  always_comb begin
    if (row_width_q == '0) begin
      eff_width = WidthW'(1);
    end else if (row_width_q > WidthW'(MaxWidth)) begin
      eff_width = WidthW'(MaxWidth);
    end else begin
      eff_width = row_width_q;
    end
  end

  assign row_end = ({1'b0, col_q} + WidthW'(1)) >= eff_width;
  assign col_d   = row_end ? '0 : col_q + ColW'(1);
  // padding only for bgr without alpha
  assign pad_n   = (row_end && !rgb_order_q && !alpha_out_q) ? eff_width[1:0] : 2'd0;

  // handshake and stage movement
  assign n_total    = n_data_q + {1'b0, n_pad_q};
  assign out_last   = (idx_q == n_total - 3'd1);
  assign out_fire   = buf_valid_q && out_ready_i;
  assign buf_done   = out_fire && out_last;
  assign s1_move    = s1_valid_q && (!buf_valid_q || buf_done);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    buf_valid_d = buf_valid_q;
    idx_d       = idx_q;
    if (s1_move) begin
      buf_valid_d = 1'b1;
      idx_d       = 3'd0;
    end else if (buf_done) begin
      buf_valid_d = 1'b0;
    end else if (out_fire) begin
      idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      buf_valid_q <= 1'b0;
      idx_q       <= 3'd0;
      col_q       <= '0;
      n_data_q    <= 3'd3;
      n_pad_q     <= 2'd0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      buf_valid_q <= buf_valid_d;
      idx_q       <= idx_d;
      if (s1_move) begin
        col_q    <= col_d;
        n_data_q <= alpha_out_q ? 3'd4 : 3'd3;
        n_pad_q  <= pad_n;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q <= pixel_word_i;
    end
    if (s1_move) begin
      bytes_q[0] <= rgb_order_q ? color.r : color.b;
      bytes_q[1] <= color.g;
      bytes_q[2] <= rgb_order_q ? color.b : color.r;
      bytes_q[3] <= color.a;
    end
  end

  // byte select: data bytes first, then zero padding
  assign is_data         = idx_q < n_data_q;
  assign out_valid_o     = buf_valid_q;
  assign out_byte_o      = is_data ? bytes_q[idx_q[1:0]] : 8'h00;
  assign is_padding_o    = !is_data;
  assign last_of_pixel_o = out_last;

  // a buffered pixel always has between three and six bytes
  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_valid_q |-> (n_total >= 3'd3 && n_total <= 3'd6))
    else $error("byte count of buffered pixel out of range");

  // the serializer index never runs past the pixel's last byte
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_valid_q |-> (idx_q < n_total))
    else $error("serializer index past last byte");

  // padding bytes only follow a three-byte pixel
  a_pad_no_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (buf_valid_q && n_pad_q != 2'd0) |-> (n_data_q == 3'd3))
    else $error("row padding with alpha byte");

  // finishing a pixel with nothing waiting empties the buffer
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (buf_done && !s1_valid_q) |=> !buf_valid_q)
    else $error("buffer not emptied after last byte");

  // a transfer on a non-final byte advances the index by one
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !out_last) |=> (idx_q == $past(idx_q) + 3'd1))
    else $error("serializer index did not advance");

endmodule

>>> tb/pixel_format_to_rgb_bytes_tb.sv
// testbench for pixel_format_to_rgb_bytes: predicted byte stream checked per transfer
`timescale 1ns / 100ps

module pixel_format_to_rgb_bytes_tb;
  import pfrgb_pkg::*;

  // wait after the last byte to catch stray output
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomPixels = 85;
  // first register index past the defined ones; writes there must be dropped
  localparam logic [CfgIdxW-1:0] FirstUnusedIdx = CfgIdxW'(RegRowWidth) + 8'd1;

  // one output byte as predicted
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             pad;
    logic             last;
  } out_beat_t;

  // mirror of the register file and row position, plus the bytes still owed
  class pixel_byte_checker;
    logic [2:0]        src_fmt;
    logic              rgb_first;
    logic              with_alpha;
    logic [WidthW-1:0] row_px;
    logic [ColW-1:0]   col;
    out_beat_t         awaited_bytes[$];
    int                errors;

    function new();
      src_fmt    = FmtBgra;
      rgb_first  = 1'b0;
      with_alpha = 1'b1;
      row_px     = WidthW'(1);
      col        = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegSourceFormat: src_fmt    = data[2:0];
        RegRgbOrder:     rgb_first  = data[0];
        RegAlphaOut:     with_alpha = data[0];
        RegRowWidth:     row_px     = data[WidthW-1:0];
        default: ;
      endcase
    endfunction

    // floor(f * 255) clamped to 0..255; sign bit set or nan gives 0
    function logic [ByteW-1:0] float_to_depth(logic [WordW-1:0] bits);
      logic [7:0]  ex;
      logic [63:0] m;
      int          sh;
      ex = bits[30:23];
      if (bits[31]) return 8'd0;
      if (ex == 8'hFF) return (bits[22:0] != 0) ? 8'd0 : 8'd255;
      if (ex >= 8'd127) return 8'd255;
      if (ex == 8'd0) begin
        m  = {41'd0, bits[22:0]};
        sh = 149;
      end else begin
        m  = {40'd0, 1'b1, bits[22:0]};
        sh = 150 - int'(ex);
      end
      if (sh >= 64) return 8'd0;
      m = (m * 64'd255) >> sh;
      return m[7:0];
    endfunction

    function void note_pixel(logic [WordW-1:0] word);
      logic [ByteW-1:0]  r, g, b, a, d;
      logic [63:0]       prod;
      logic [WidthW-1:0] eff;
      out_beat_t         beats[$];
      r = '0;
      g = '0;
      b = '0;
      a = 8'hFF;
      case (src_fmt)
        FmtRgba: {a, b, g, r} = word;
        FmtBgr:  {r, g, b} = word[23:0];
        FmtBgra: {a, r, g, b} = word;
        FmtFloatDepth: begin
          d = float_to_depth(word);
          {r, g, b} = {d, d, d};
        end
        FmtDepth24: begin
          prod = ({40'd0, word[23:0]} * 64'd255) / 64'hFF_FFFF;
          {r, g, b} = {3{prod[7:0]}};
        end
        FmtDepth16: begin
          prod = ({48'd0, word[15:0]} * 64'd255) / 64'hFFFF;
          {r, g, b} = {3{prod[7:0]}};
        end
        default: ;  // unused codes: black, opaque
      endcase
      if (rgb_first) begin
        beats.push_back('{r, 1'b0, 1'b0});
        beats.push_back('{g, 1'b0, 1'b0});
        beats.push_back('{b, 1'b0, 1'b0});
      end else begin
        beats.push_back('{b, 1'b0, 1'b0});
        beats.push_back('{g, 1'b0, 1'b0});
        beats.push_back('{r, 1'b0, 1'b0});
      end
      if (with_alpha) beats.push_back('{a, 1'b0, 1'b0});
      eff = row_px;
      if (eff == 0) eff = WidthW'(1);
      if (eff > MaxWidth) eff = WidthW'(MaxWidth);
      // row end also when width shrank below the current column
      if (int'(col) + 1 >= int'(eff)) begin
        col = '0;
        if (!rgb_first && !with_alpha) begin
          for (int i = 0; i < int'(eff[1:0]); i++) beats.push_back('{8'h00, 1'b1, 1'b0});
        end
      end else begin
        col = col + 1'b1;
      end
      beats[beats.size()-1].last = 1'b1;
      foreach (beats[i]) awaited_bytes.push_back(beats[i]);
    endfunction

    function void check_byte(logic [ByteW-1:0] data, logic pad, logic last);
      out_beat_t want;
      if (awaited_bytes.size() == 0) begin
        $display("%0t: unexpected byte %02h pad %0b last %0b", $time, data, pad, last);
        errors++;
        return;
      end
      want = awaited_bytes.pop_front();
      if (want.data !== data || want.pad !== pad || want.last !== last) begin
        $display("%0t: mismatch: expected byte %02h pad %0b last %0b, got %02h pad %0b last %0b",
                 $time, want.data, want.pad, want.last, data, pad, last);
        errors++;
      end
    endfunction

    function int pending_count();
      return awaited_bytes.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [WordW-1:0]    pixel_word_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [ByteW-1:0]    out_byte_o;
  logic                is_padding_o;
  logic                last_of_pixel_o;

  // idle percentages of the pixel sender and the byte receiver
  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 71;

  pixel_byte_checker board = new();

  pixel_format_to_rgb_bytes dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_word_i   (pixel_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .is_padding_o   (is_padding_o),
    .last_of_pixel_o(last_of_pixel_o)
  );

  always #1 clk_i = ~clk_i;

  // receiver backpressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // all transfers are observed here, in one place, so the order within an edge is fixed:
  // register writes, then new pixels, then checked bytes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) board.note_pixel(pixel_word_i);
      if (out_valid_o && out_ready_i) board.check_byte(out_byte_o, is_padding_o, last_of_pixel_o);
    end
  end

  // sender idles at random, then holds valid and the word until the transfer
  task automatic send_pixel(input logic [WordW-1:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pixel_word_i <= word;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop sending and wait until every predicted byte has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending_count() != 0);
  endtask

  // registers only change with the pipeline empty
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // unused upper data bits carry random junk that the block must drop
  task automatic configure(input logic [2:0] fmt, input logic order, input logic alpha,
                           input logic [WidthW-1:0] px);
    write_reg(RegSourceFormat, {11'($urandom), fmt});
    write_reg(RegRgbOrder, {13'($urandom), order});
    write_reg(RegAlphaOut, {13'($urandom), alpha});
    write_reg(RegRowWidth, px);
  endtask

  // word for the current format: float depth leans toward the interesting
  // exponent range and special codes, the rest is mostly uniform
  function automatic logic [WordW-1:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (board.src_fmt == FmtFloatDepth) begin
      case (sel)
        2: return 32'h7F80_0000;  // +inf
        3: return 32'h7FC0_0000 | 32'($urandom_range(0, 32'h3F_FFFF));  // nan
        4: return 32'h3F80_0000;  // 1.0
        5: return {9'h000, 23'($urandom)};  // denormal
        default: begin
          if (sel < 16) return {1'b0, 8'($urandom_range(110, 127)), 23'($urandom)};
          return $urandom;
        end
      endcase
    end
    return $urandom;
  endfunction

  task automatic set_idle(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 17;
        recv_idle_pct = 71;
      end
      1: begin
        send_idle_pct = 71;
        recv_idle_pct = 17;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  initial begin
    int unsigned       sent;
    int unsigned       burst;
    int unsigned       pick;
    logic [WidthW-1:0] px;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: bgra in, b,g,r,a out, one pixel per row
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h1234_5678);

    // rgba straight through in r,g,b order
    configure(FmtRgba, 1'b1, 1'b1, WidthW'(3));
    send_pixel(32'hA5C3_3C5A);
    send_pixel(32'h8001_FE7F);

    // bgr without alpha: three padding bytes close each row of three
    configure(FmtBgr, 1'b0, 1'b0, WidthW'(3));
    send_pixel(32'hFF00_FF00);
    send_pixel(32'h00FF_00FF);
    send_pixel(32'hAA55_AA55);
    send_pixel(32'h55AA_55AA);

    // float depth: saturation, nan, negative zero, midpoint, just below one, denormal
    configure(FmtFloatDepth, 1'b1, 1'b0, WidthW'(1));
    send_pixel(32'h3F80_0000);
    send_pixel(32'h7F80_0000);
    send_pixel(32'h7FC0_0000);
    send_pixel(32'h8000_0000);
    send_pixel(32'h3F00_0000);
    send_pixel(32'h3F7F_FFFF);
    send_pixel(32'h0000_0001);

    // 24-bit depth, width zero counts as one: one pad byte per pixel
    configure(FmtDepth24, 1'b0, 1'b0, WidthW'(0));
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0080_0000);

    // 16-bit depth, widest register value clamps to the maximum row
    configure(FmtDepth16, 1'b0, 1'b0, '1);
    send_pixel(32'h0000_FFFF);
    send_pixel(32'hABCD_8000);

    // unused format code via junk-laden data, plus a write to a missing register
    write_reg(RegSourceFormat, '1);
    write_reg(FirstUnusedIdx, '0);
    write_reg(RegAlphaOut, 14'd1);
    write_reg(RegRowWidth, WidthW'(2));
    send_pixel(32'h1357_9BDF);
    send_pixel(32'hFDB9_7531);

    // random phases: random register set, then a burst of pixels
    sent = 0;
    while (sent < RandomPixels) begin
      set_idle(sent * 3 / RandomPixels);
      if ($urandom_range(0, 3) != 0) write_reg(RegSourceFormat, 14'($urandom));
      if ($urandom_range(0, 3) != 0) write_reg(RegRgbOrder, 14'($urandom));
      if ($urandom_range(0, 3) != 0) write_reg(RegAlphaOut, 14'($urandom));
      if ($urandom_range(0, 3) != 0) begin
        // mostly short rows so padding shows up often
        pick = $urandom_range(0, 9);
        case (pick)
          0: px = WidthW'(0);
          1: px = WidthW'(MaxWidth - 1);
          2: px = WidthW'(MaxWidth);
          3: px = 14'($urandom);
          default: px = WidthW'($urandom_range(1, 9));
        endcase
        write_reg(RegRowWidth, px);
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(CfgIdxW'($urandom_range(int'(FirstUnusedIdx), 255)), 14'($urandom));
      end
      burst = $urandom_range(1, 12);
      repeat (burst) send_pixel(pick_word());
      sent += burst;
    end

    set_idle(2);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (board.pending_count() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, board.pending_count());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("pixel_format_to_rgb_bytes_tb: PASS");
    end else begin
      $display("pixel_format_to_rgb_bytes_tb: FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #400000;
    $display("pixel_format_to_rgb_bytes_tb: FAIL");
    $finish;
  end

endmodule

>>> files.f
src/pfrgb_pkg.sv
src/pfrgb_convert.sv
src/pixel_format_to_rgb_bytes.sv
tb/pixel_format_to_rgb_bytes_tb.sv
